/* rtl/bpfa_pkg.sv */
// bpfa_pkg: shared types and constants of the bitmap page frame allocator
// depends on nothing; imported by bpfa_word_unit and bitmap_page_frame_allocator
package bpfa_pkg;

  // sizing of the frame map
  localparam int unsigned WORD_BITS  = 32;
  localparam int unsigned BIT_W      = $clog2(WORD_BITS);
  localparam int unsigned MAP_FRAMES = 65536;
  localparam int unsigned MAP_WORDS  = MAP_FRAMES / WORD_BITS;
  localparam int unsigned WADDR_W    = $clog2(MAP_WORDS);
  localparam int unsigned FIDX_W     = $clog2(MAP_FRAMES);
  localparam int unsigned COUNT_W    = 17;
  localparam int unsigned PAGE_SHIFT = 12;
  localparam int unsigned BYTE_W     = 33;
  localparam int unsigned ADDR_W     = 32;
  // frame numbers before clamping, wide enough for a rounded-up 33-bit address
  localparam int unsigned RAW_W      = BYTE_W + 1 - PAGE_SHIFT;
  localparam int unsigned FRAME_LIM_4G = 1 << (ADDR_W - PAGE_SHIFT);

  // command codes
  typedef enum logic [1:0] {
    CMD_ALLOC   = 2'd0,
    CMD_FREE    = 2'd1,
    CMD_RESERVE = 2'd2,
    CMD_SET_ALL = 2'd3
  } cmd_e;

  // status codes
  localparam logic [1:0] STAT_OK     = 2'd0;
  localparam logic [1:0] STAT_NOMEM  = 2'd1;
  localparam logic [1:0] STAT_NOINIT = 2'd2;

  // input word
  typedef struct packed {
    logic [1:0]        command;
    logic [BYTE_W-1:0] range_start;
    logic [BYTE_W-1:0] range_end;
  } in_word_t;

  // result word
  typedef struct packed {
    logic [1:0]        status;
    logic [ADDR_W-1:0] frame_address;
  } out_word_t;

  // request to the word unit: one map word and the frame span that applies
  typedef struct packed {
    cmd_e                 op;
    logic [WADDR_W-1:0]   word_idx;
    logic [FIDX_W-1:0]    span_lo;
    logic [COUNT_W-1:0]   span_hi;
  } word_req_t;

  // answer from the word unit
  typedef struct packed {
    logic             found;
    logic [BIT_W-1:0] bit_idx;
  } word_rsp_t;

endpackage

/* rtl/bpfa_word_unit.sv */
// bpfa_word_unit: modifies one frame map word within a frame span
// depends on bpfa_pkg; used by bitmap_page_frame_allocator
module bpfa_word_unit (
  input  bpfa_pkg::word_req_t                 req_i,
  input  logic [bpfa_pkg::WORD_BITS-1:0]      data_i,
  output logic [bpfa_pkg::WORD_BITS-1:0]      data_o,
  output bpfa_pkg::word_rsp_t                 rsp_o
);
  import bpfa_pkg::*;

  logic [WORD_BITS-1:0] lo_mask;
  logic [WORD_BITS-1:0] hi_mask;
  logic [WORD_BITS-1:0] span_mask;
  logic [WORD_BITS-1:0] cand;
  logic [WORD_BITS-1:0] first_free;

  // bits of this word that lie inside the span
  always_comb begin
    if (req_i.word_idx == req_i.span_lo[FIDX_W-1:BIT_W]) begin
      lo_mask = {WORD_BITS{1'b1}} << req_i.span_lo[BIT_W-1:0];
    end else begin
      lo_mask = {WORD_BITS{1'b1}};
    end
    if ({1'b0, req_i.word_idx} == req_i.span_hi[COUNT_W-1:BIT_W]) begin
      hi_mask = (WORD_BITS'(1) << req_i.span_hi[BIT_W-1:0]) - WORD_BITS'(1);
    end else begin
      hi_mask = {WORD_BITS{1'b1}};
    end
    span_mask = lo_mask & hi_mask;
  end

  // lowest free frame inside the span
  assign cand       = ~data_i & span_mask;
  assign first_free = cand & (~cand + WORD_BITS'(1));

  always_comb begin
    rsp_o.found   = |cand;
    rsp_o.bit_idx = '0;
    for (int b = WORD_BITS - 1; b >= 0; b--) begin
      if (cand[b]) begin
        rsp_o.bit_idx = BIT_W'(b);
      end
    end
  end

  // new word value per command
  always_comb begin
    case (req_i.op)
      CMD_FREE:    data_o = data_i & ~span_mask;
      CMD_RESERVE: data_o = data_i | span_mask;
      CMD_ALLOC:   data_o = data_i | first_free;
      default:     data_o = {WORD_BITS{1'b1}};
    endcase
  end

endmodule

/* rtl/bitmap_page_frame_allocator.sv */
// bitmap_page_frame_allocator: top level, sequencer and frame map memory
// depends on bpfa_pkg and bpfa_word_unit
//
// Usage:
//   cfg channel: frame_count is written when cfg_valid_i and cfg_ready_o are
//   high; write it only while the block is idle. Zero means not initialized.
//   in channel: a command word is taken when in_valid_i is high and
//   in_stall_o is low. in_stall_o stays high while a command is in work.
//   out channel: exactly one result word per command, held in an output
//   register while out_stall_i is high; the next command may be taken
//   while that result still waits.
//   Timing: the map lives in a 2048 x 32 memory with one read and one write
//   port. Allocate and range commands stream one map word per cycle through
//   the shared word unit; an allocate stops at the first word with a free
//   frame. Set-all-used sweeps every word. A stalled receiver holds the
//   block in its result state once the next result is ready.
//   Reset: a clearing pass over all 2048 map words marks every frame used;
//   no command is taken during it, configuration writes are.
module bitmap_page_frame_allocator (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [bpfa_pkg::COUNT_W-1:0]  cfg_data_i,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  bpfa_pkg::in_word_t            in_data_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output bpfa_pkg::out_word_t           out_data_o
);
  import bpfa_pkg::*;

  typedef enum logic [4:0] {
    ST_CLEAR = 5'b00001,
    ST_IDLE  = 5'b00010,
    ST_SETUP = 5'b00100,
    ST_SCAN  = 5'b01000,
    ST_RESP  = 5'b10000
  } state_e;

  state_e state_q, state_d;

  logic [COUNT_W-1:0]   frame_count_q;
  cmd_e                 op_q, op_d;
  logic [RAW_W-1:0]     lo_raw_q, lo_raw_d;
  logic [RAW_W-1:0]     hi_raw_q, hi_raw_d;
  logic [FIDX_W-1:0]    span_lo_q, span_lo_d;
  logic [COUNT_W-1:0]   span_hi_q, span_hi_d;
  logic [WADDR_W-1:0]   issue_addr_q, issue_addr_d;
  logic                 issue_done_q, issue_done_d;
  logic [WADDR_W-1:0]   last_word_q, last_word_d;
  logic                 pv_q, pv_d;
  logic [WADDR_W-1:0]   p_addr_q, p_addr_d;
  logic [WADDR_W-1:0]   clr_addr_q, clr_addr_d;
  logic                 clr_resp_q, clr_resp_d;
  logic [1:0]           res_status_q, res_status_d;
  logic [ADDR_W-1:0]    res_addr_q, res_addr_d;
  logic                 out_valid_q, out_valid_d;
  out_word_t            out_q, out_d;

  // frame map memory
  logic [WORD_BITS-1:0] map_mem [MAP_WORDS];
  logic [WORD_BITS-1:0] rd_data_q;
  logic                 rd_en;
  logic [WADDR_W-1:0]   rd_addr;
  logic                 wr_en;
  logic [WADDR_W-1:0]   wr_addr;
  logic [WORD_BITS-1:0] wr_data;

  // word unit
  word_req_t            wu_req;
  word_rsp_t            wu_rsp;
  logic [WORD_BITS-1:0] wu_data;

  // command decode on the input word
  logic [BYTE_W:0]      start_up;
  logic [BYTE_W:0]      end_up;
  logic [RAW_W-2:0]     end_dn;

  // span clamping
  logic [COUNT_W-1:0]   managed;
  logic [COUNT_W-1:0]   hi_clamp;
  logic [COUNT_W-1:0]   hi_m1;

  logic                 in_acc;
  logic                 out_free;
  logic                 alloc_hit;
  logic                 scan_end;
  logic                 issue;

  assign cfg_ready_o = 1'b1;
  assign in_stall_o  = (state_q != ST_IDLE);
  assign in_acc      = in_valid_i && !in_stall_o;
  assign out_free    = !out_valid_q || !out_stall_i;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // frame numbers of the range ends, rounded both ways
  assign start_up = {1'b0, in_data_i.range_start} +
                    {{(BYTE_W+1-PAGE_SHIFT){1'b0}}, {PAGE_SHIFT{1'b1}}};
  assign end_up   = {1'b0, in_data_i.range_end} +
                    {{(BYTE_W+1-PAGE_SHIFT){1'b0}}, {PAGE_SHIFT{1'b1}}};
  assign end_dn   = in_data_i.range_end[BYTE_W-1:PAGE_SHIFT];

  // effective count and clamped span end
  always_comb begin
    managed  = (frame_count_q > COUNT_W'(MAP_FRAMES)) ? COUNT_W'(MAP_FRAMES) : frame_count_q;
    hi_clamp = (hi_raw_q > RAW_W'(managed)) ? managed : hi_raw_q[COUNT_W-1:0];
    hi_m1    = hi_clamp - COUNT_W'(1);
  end

  bpfa_word_unit u_word (
    .req_i  (wu_req),
    .data_i (rd_data_q),
    .data_o (wu_data),
    .rsp_o  (wu_rsp)
  );

  always_comb begin
    wu_req.op       = op_q;
    wu_req.word_idx = p_addr_q;
    wu_req.span_lo  = span_lo_q;
    wu_req.span_hi  = span_hi_q;
  end

  assign alloc_hit = pv_q && (op_q == CMD_ALLOC) && wu_rsp.found;
  assign scan_end  = pv_q && (alloc_hit || (p_addr_q == last_word_q));
  assign issue     = (state_q == ST_SCAN) && !issue_done_q && !alloc_hit;

  // sequencer
  always_comb begin
    state_d      = state_q;
    op_d         = op_q;
    lo_raw_d     = lo_raw_q;
    hi_raw_d     = hi_raw_q;
    span_lo_d    = span_lo_q;
    span_hi_d    = span_hi_q;
    issue_addr_d = issue_addr_q;
    issue_done_d = issue_done_q;
    last_word_d  = last_word_q;
    pv_d         = 1'b0;
    p_addr_d     = p_addr_q;
    clr_addr_d   = clr_addr_q;
    clr_resp_d   = clr_resp_q;
    res_status_d = res_status_q;
    res_addr_d   = res_addr_q;
    out_valid_d  = out_valid_q && out_stall_i;
    out_d        = out_q;
    rd_en        = 1'b0;
    rd_addr      = issue_addr_q;
    wr_en        = 1'b0;
    wr_addr      = p_addr_q;
    wr_data      = wu_data;

    case (state_q)
      // sweep every word to all used
      ST_CLEAR: begin
        wr_en      = 1'b1;
        wr_addr    = clr_addr_q;
        wr_data    = {WORD_BITS{1'b1}};
        clr_addr_d = clr_addr_q + WADDR_W'(1);
        if (clr_addr_q == WADDR_W'(MAP_WORDS - 1)) begin
          state_d = clr_resp_q ? ST_RESP : ST_IDLE;
        end
      end
      // take a command word
      ST_IDLE: begin
        if (in_acc) begin
          op_d         = cmd_e'(in_data_i.command);
          res_status_d = STAT_OK;
          res_addr_d   = '0;
          state_d      = ST_SETUP;
          case (cmd_e'(in_data_i.command))
            CMD_ALLOC: begin
              lo_raw_d = '0;
              hi_raw_d = RAW_W'(frame_count_q);
              if (frame_count_q == '0) begin
                res_status_d = STAT_NOINIT;
                state_d      = ST_RESP;
              end
            end
            CMD_FREE: begin
              lo_raw_d = start_up[RAW_W+PAGE_SHIFT-1-:RAW_W] ;
              hi_raw_d = (end_dn > (RAW_W-1)'(FRAME_LIM_4G)) ?
                         RAW_W'(FRAME_LIM_4G) : RAW_W'(end_dn);
            end
            CMD_RESERVE: begin
              lo_raw_d = RAW_W'(in_data_i.range_start[BYTE_W-1:PAGE_SHIFT]);
              hi_raw_d = end_up[RAW_W+PAGE_SHIFT-1-:RAW_W];
            end
            default: begin
              clr_addr_d = '0;
              clr_resp_d = 1'b1;
              state_d    = ST_CLEAR;
            end
          endcase
        end
      end
      // clamp the span to the managed frames
      ST_SETUP: begin
        span_lo_d    = lo_raw_q[FIDX_W-1:0];
        span_hi_d    = hi_clamp;
        issue_addr_d = lo_raw_q[FIDX_W-1:BIT_W];
        last_word_d  = hi_m1[FIDX_W-1:BIT_W];
        issue_done_d = 1'b0;
        if (lo_raw_q < RAW_W'(hi_clamp)) begin
          state_d = ST_SCAN;
        end else begin
          state_d = ST_RESP;
        end
      end
      // read one word a cycle, modify and write back the one before
      ST_SCAN: begin
        if (issue) begin
          rd_en        = 1'b1;
          pv_d         = 1'b1;
          p_addr_d     = issue_addr_q;
          issue_addr_d = issue_addr_q + WADDR_W'(1);
          issue_done_d = (issue_addr_q == last_word_q);
        end
        if (pv_q) begin
          wr_en = (op_q != CMD_ALLOC) || wu_rsp.found;
        end
        if (alloc_hit) begin
          res_addr_d = ADDR_W'({p_addr_q, wu_rsp.bit_idx}) << PAGE_SHIFT;
        end else if (scan_end && (op_q == CMD_ALLOC)) begin
          res_status_d = STAT_NOMEM;
        end
        if (scan_end) begin
          state_d = ST_RESP;
        end
      end
      // hand the result to the output register
      ST_RESP: begin
        if (out_free) begin
          out_valid_d          = 1'b1;
          out_d.status         = res_status_q;
          out_d.frame_address  = res_addr_q;
          clr_resp_d           = 1'b0;
          state_d              = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= ST_CLEAR;
      clr_addr_q    <= '0;
      clr_resp_q    <= 1'b0;
      pv_q          <= 1'b0;
      issue_done_q  <= 1'b0;
      out_valid_q   <= 1'b0;
      frame_count_q <= '0;
    end else begin
      state_q      <= state_d;
      clr_addr_q   <= clr_addr_d;
      clr_resp_q   <= clr_resp_d;
      pv_q         <= pv_d;
      issue_done_q <= issue_done_d;
      out_valid_q  <= out_valid_d;
      if (cfg_valid_i && cfg_ready_o) begin
        frame_count_q <= cfg_data_i;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    op_q         <= op_d;
    lo_raw_q     <= lo_raw_d;
    hi_raw_q     <= hi_raw_d;
    span_lo_q    <= span_lo_d;
    span_hi_q    <= span_hi_d;
    issue_addr_q <= issue_addr_d;
    last_word_q  <= last_word_d;
    p_addr_q     <= p_addr_d;
    res_status_q <= res_status_d;
    res_addr_q   <= res_addr_d;
    out_q        <= out_d;
  end

  // memory ports
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      map_mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_q <= map_mem[rd_addr];
    end
  end

endmodule

/* tb/bitmap_page_frame_allocator_test.sv */
// bitmap_page_frame_allocator_test: self-checking testbench for the page frame allocator
// depends on bpfa_pkg and bitmap_page_frame_allocator; a local model of the frame map
// predicts every result word, with random idling on both channels
`timescale 1ns / 1ps

module bitmap_page_frame_allocator_test;
  import bpfa_pkg::*;

  localparam longint unsigned SEARCH_LIMIT = 65536;
  localparam longint unsigned PAGE_BYTES   = 64'd1 << PAGE_SHIFT;
  localparam longint unsigned ADDR_LIMIT   = 64'd1 << ADDR_W;
  localparam logic [BYTE_W-1:0] BYTE_MAX   = '1;
  // run time limit in nanoseconds for the hard stop below
  localparam longint unsigned RUN_LIMIT_NS = 64'd20_000_000;
  localparam int unsigned SETTLE_CYCLES    = 2100;

  logic       clk_i;
  logic       rst_ni;
  logic       cfg_valid_i;
  logic       cfg_ready_o;
  logic [COUNT_W-1:0] cfg_data_i;
  logic       in_valid_i;
  logic       in_stall_o;
  in_word_t   in_data_i;
  logic       out_valid_o;
  logic       out_stall_i;
  out_word_t  out_data_o;

  bitmap_page_frame_allocator dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_data_i  (cfg_data_i),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

  // clock, 8 ns period
  always begin
    clk_i = 1'b0;
    #4;
    clk_i = 1'b1;
    #4;
  end

  // model of the frame map and the frame count register
  bit [MAP_FRAMES-1:0] frame_used;
  logic [COUNT_W-1:0]  frame_count_model;

  out_word_t pending_results[$];
  out_word_t expected_word;

  int send_gap_max = 16;
  int stall_max    = 16;
  int mismatch_count;
  int n_granted, n_nomem, n_noinit, n_free, n_reserve, n_set_all, n_count_writes;

  function automatic longint unsigned managed_frames();
    return (frame_count_model > MAP_FRAMES) ? longint'(MAP_FRAMES) : longint'(frame_count_model);
  endfunction

  // set or clear frames [lo, hi) below the managed count
  function automatic void mark_span(longint unsigned lo, longint unsigned hi, bit used);
    longint unsigned n;
    n = managed_frames();
    if (hi > n) hi = n;
    for (longint unsigned f = lo; f < hi; f++) frame_used[f] = used;
  endfunction

  // applies one command word to the map model and returns its result word
  function automatic out_word_t apply_command(in_word_t w);
    out_word_t r;
    longint unsigned s, e, sa, ea, lim, pick, addr;
    bit hit;
    r = '0;
    s = w.range_start;
    e = w.range_end;
    case (w.command)
      CMD_ALLOC: begin
        if (frame_count_model == 0) begin
          r.status = STAT_NOINIT;
        end else begin
          lim = managed_frames();
          if (lim > SEARCH_LIMIT) lim = SEARCH_LIMIT;
          hit = 1'b0;
          pick = 0;
          for (longint unsigned f = 0; f < lim && !hit; f++) begin
            if (!frame_used[f]) begin
              hit = 1'b1;
              pick = f;
            end
          end
          if (hit) begin
            frame_used[pick] = 1'b1;
            addr = pick << PAGE_SHIFT;
            r.status = STAT_OK;
            r.frame_address = addr[ADDR_W-1:0];
          end else begin
            r.status = STAT_NOMEM;
          end
        end
      end
      CMD_FREE: begin
        // round start up, end down, clamp end at 4 GiB
        sa = ((s + PAGE_BYTES - 1) >> PAGE_SHIFT) << PAGE_SHIFT;
        ea = (e >> PAGE_SHIFT) << PAGE_SHIFT;
        if (ea > ADDR_LIMIT) ea = ADDR_LIMIT;
        if (sa < ea) mark_span(sa >> PAGE_SHIFT, ea >> PAGE_SHIFT, 1'b0);
      end
      CMD_RESERVE: begin
        mark_span(s >> PAGE_SHIFT, (e + PAGE_BYTES - 1) >> PAGE_SHIFT, 1'b1);
      end
      default: begin
        frame_used = '1;
      end
    endcase
    return r;
  endfunction

  function automatic logic [BYTE_W-1:0] frame_bytes(longint unsigned f);
    longint unsigned a;
    a = f << PAGE_SHIFT;
    return a[BYTE_W-1:0];
  endfunction

  // byte address inside or at the start of a frame
  function automatic logic [BYTE_W-1:0] near_frame_address(longint unsigned f);
    longint unsigned a;
    a = f << PAGE_SHIFT;
    if ($urandom_range(0, 3) != 0) a = a + $urandom_range(0, PAGE_BYTES - 1);
    return a[BYTE_W-1:0];
  endfunction

  function automatic logic [BYTE_W-1:0] random_bytes();
    logic [63:0] r64;
    r64 = {$urandom, $urandom};
    return r64[BYTE_W-1:0];
  endfunction

  task automatic report_mismatch(string what);
    if (mismatch_count < 40) $display("[%0t] mismatch: %s", $realtime, what);
    mismatch_count++;
  endtask

  // sends one command word, predicts its result at acceptance
  task automatic send_command(cmd_e c, logic [BYTE_W-1:0] s, logic [BYTE_W-1:0] e);
    in_word_t  w;
    out_word_t r;
    int gap;
    w.command = c;
    w.range_start = s;
    w.range_end = e;
    in_valid_i <= 1'b1;
    in_data_i  <= w;
    do @(posedge clk_i); while (in_stall_o);
    r = apply_command(w);
    pending_results.push_back(r);
    case (c)
      CMD_ALLOC: begin
        if (r.status == STAT_OK) n_granted++;
        else if (r.status == STAT_NOMEM) n_nomem++;
        else n_noinit++;
      end
      CMD_FREE:    n_free++;
      CMD_RESERVE: n_reserve++;
      default:     n_set_all++;
    endcase
    gap = $urandom_range(0, send_gap_max);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  // hold the sender until every predicted word has come back
  task automatic wait_all_results();
    in_valid_i <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
  endtask

  task automatic write_frame_count(int unsigned v);
    wait_all_results();
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= v[COUNT_W-1:0];
    do @(posedge clk_i); while (!cfg_ready_o);
    frame_count_model = v[COUNT_W-1:0];
    n_count_writes++;
    cfg_valid_i <= 1'b0;
  endtask

  // result side stall, one draw per word
  initial begin : result_stall
    int n;
    out_stall_i = 1'b0;
    wait (rst_ni === 1'b1);
    forever begin
      n = $urandom_range(0, stall_max);
      if (n > 0) begin
        out_stall_i <= 1'b1;
        repeat (n) @(posedge clk_i);
      end
      out_stall_i <= 1'b0;
      do @(posedge clk_i); while (!out_valid_o);
    end
  end

  // compare each accepted result word with the oldest prediction
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_results.size() == 0) begin
        report_mismatch("result word with nothing expected");
      end else begin
        expected_word = pending_results.pop_front();
        if (out_data_o.status !== expected_word.status)
          report_mismatch($sformatf("status got %0d expected %0d",
                                    out_data_o.status, expected_word.status));
        if (out_data_o.frame_address !== expected_word.frame_address)
          report_mismatch($sformatf("frame_address got %h expected %h",
                                    out_data_o.frame_address, expected_word.frame_address));
      end
    end
  end

  // allocate and range commands before any frame count is set
  task automatic test_uninitialised();
    write_frame_count(0);
    send_command(CMD_ALLOC, '0, '0);
    send_command(CMD_FREE, '0, BYTE_MAX);
    send_command(CMD_ALLOC, BYTE_MAX, BYTE_MAX);
  endtask

  // every frame reads used after reset
  task automatic test_reset_state();
    write_frame_count(8);
    send_command(CMD_ALLOC, '0, '0);
    send_command(CMD_RESERVE, BYTE_MAX, '0);
  endtask

  // free range rounds the start up and the end down
  task automatic test_free_rounding();
    write_frame_count(64);
    send_command(CMD_FREE, 33'd1, 33'd8191);
    send_command(CMD_ALLOC, '0, '0);
    send_command(CMD_FREE, 33'd4095, frame_bytes(3) + 33'd100);
    send_command(CMD_ALLOC, '0, '0);
    send_command(CMD_ALLOC, '0, '0);
    send_command(CMD_ALLOC, '0, '0);
    send_command(CMD_FREE, frame_bytes(2), frame_bytes(1));
  endtask

  // reserve range widens to whole frames; empty range does nothing
  task automatic test_reserve_rounding();
    send_command(CMD_FREE, '0, frame_bytes(64));
    send_command(CMD_RESERVE, 33'd4095, 33'd4097);
    send_command(CMD_ALLOC, '0, '0);
    send_command(CMD_RESERVE, '0, '0);
  endtask

  // oversized count, 4 GiB clamp, top frame address, ranges past the count
  task automatic test_count_extremes();
    write_frame_count((1 << COUNT_W) - 1);
    send_command(CMD_FREE, '0, BYTE_MAX);
    send_command(CMD_ALLOC, '0, '0);
    send_command(CMD_RESERVE, '0, BYTE_MAX);
    send_command(CMD_ALLOC, '0, '0);
    send_command(CMD_FREE, frame_bytes(MAP_FRAMES - 1), BYTE_MAX);
    send_command(CMD_ALLOC, '0, '0);
    write_frame_count(MAP_FRAMES);
    send_command(CMD_RESERVE, BYTE_MAX, BYTE_MAX);
  endtask

  task automatic test_set_all_used();
    send_command(CMD_FREE, '0, frame_bytes(10));
    send_command(CMD_SET_ALL, BYTE_MAX, BYTE_MAX);
    send_command(CMD_ALLOC, '0, '0);
  endtask

  // mostly well-formed frees, reserves and allocates near the managed frames,
  // with a little noise and the odd set-all-used
  task automatic test_random_mix(int unsigned count, int items, int gmax, int smax);
    longint unsigned top, lo;
    int pick;
    write_frame_count(count);
    send_gap_max = gmax;
    stall_max = smax;
    top = managed_frames() + 4;
    for (int i = 0; i < items; i++) begin
      if (i == items / 2) wait_all_results();
      pick = $urandom_range(0, 99);
      lo = $urandom_range(0, top);
      if (pick < 45) begin
        send_command(CMD_ALLOC, random_bytes(), random_bytes());
      end else if (pick < 70) begin
        send_command(CMD_FREE, near_frame_address(lo),
                     near_frame_address(lo + $urandom_range(0, 24)));
      end else if (pick < 90) begin
        send_command(CMD_RESERVE, near_frame_address(lo),
                     near_frame_address(lo + $urandom_range(0, 6)));
      end else if (pick < 93) begin
        send_command(CMD_SET_ALL, random_bytes(), random_bytes());
      end else begin
        send_command(cmd_e'($urandom_range(0, 3)), random_bytes(), random_bytes());
      end
    end
  endtask

  initial begin
    rst_ni      = 1'b0;
    cfg_valid_i = 1'b0;
    cfg_data_i  = '0;
    in_valid_i  = 1'b0;
    in_data_i   = '0;
    frame_used  = '1;
    frame_count_model = '0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    test_uninitialised();
    test_reset_state();
    test_free_rounding();
    test_reserve_rounding();
    test_count_extremes();
    test_set_all_used();
    test_random_mix(0, 10, 16, 16);
    test_random_mix(1, 25, 0, 0);
    test_random_mix(33, 50, 16, 16);
    test_random_mix(200, 50, 16, 0);
    test_random_mix(MAP_FRAMES - 1, 40, 0, 16);
    test_random_mix((1 << COUNT_W) - 1, 40, 16, 16);
    test_random_mix(MAP_FRAMES, 50, 4, 4);

    // drain, then give a stray word time to show up
    wait_all_results();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (pending_results.size() != 0)
      report_mismatch($sformatf("%0d result words never arrived", pending_results.size()));

    $display("covered allocations: %0d granted, %0d out of memory, %0d uninitialised",
             n_granted, n_nomem, n_noinit);
    $display("covered range work: %0d free, %0d reserve, %0d set-all, %0d count writes",
             n_free, n_reserve, n_set_all, n_count_writes);
    if (mismatch_count == 0) begin
      $display("PASS bitmap_page_frame_allocator");
    end else begin
      $display("FAIL bitmap_page_frame_allocator");
    end
    $finish;
  end

  // hard stop if the block hangs
  initial begin
    #(RUN_LIMIT_NS);
    $display("FAIL bitmap_page_frame_allocator");
    $finish;
  end

endmodule

/* sim.f */
rtl/bpfa_pkg.sv
rtl/bpfa_word_unit.sv
rtl/bitmap_page_frame_allocator.sv
tb/bitmap_page_frame_allocator_test.sv
